// ===== rtl/spbpm_pkg.sv =====
package spbpm_pkg;

  // Bar count. It is a power of two, so the wrapped bar index is the low bits of the bin field.
  localparam int NUM_BARS = 32;
  localparam int BAR_W    = $clog2(NUM_BARS);

  localparam int BIN_W    = 5;
  localparam int MAG_W    = 16;
  localparam int FRAC_W   = 8;
  localparam int LVL_W    = MAG_W + FRAC_W;
  localparam int COEF_W   = 8;
  localparam int FS_W     = 16;
  localparam int PX_W     = 10;
  localparam int COLOR_W  = 16;
  localparam int PROD_W   = MAG_W + PX_W;
  localparam int FRAC_ONE = 1 << FRAC_W;

  // Quotient bits resolved in each divider stage.
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = PX_W / DIV_PER_STAGE;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COEF_W-1:0] SMOOTH_RST = 8'd179;
  localparam logic [COEF_W-1:0] DECAY_RST  = 8'd243;
  localparam logic [FS_W-1:0]   FULL_RST   = 16'd500;
  localparam logic [PX_W-1:0]   HEIGHT_RST = 10'd240;

  localparam logic [4:0] BLUE_565 = 5'(128 >> 3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTH     = 2'd0,
    CFG_DECAY      = 2'd1,
    CFG_FULL_SCALE = 2'd2,
    CFG_HEIGHT     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] magnitude;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bar_bin;
    logic [PX_W-1:0]    bar_height;
    logic [PX_W-1:0]    peak_height;
    logic [PX_W-1:0]    old_bar_height;
    logic [PX_W-1:0]    old_peak_height;
    logic               erase_bar;
    logic               erase_peak;
    logic [COLOR_W-1:0] bar_color;
  } out_item_t;

  typedef struct packed {
    logic [COEF_W-1:0] smooth_factor;
    logic [COEF_W-1:0] peak_fade;
    logic [FS_W-1:0]   full_scale;
    logic [PX_W-1:0]   screen_height;
  } cfg_t;

  // Level stage to divider: integer parts of the updated levels.
  typedef struct packed {
    logic             valid;
    logic [BAR_W-1:0] idx;
    logic [MAG_W-1:0] bar_ip;
    logic [MAG_W-1:0] peak_ip;
  } lvl_out_t;

  // Divider to pixel stage: saturated screen heights.
  typedef struct packed {
    logic             valid;
    logic [BAR_W-1:0] idx;
    logic [PX_W-1:0]  bar_px;
    logic [PX_W-1:0]  peak_px;
  } div_out_t;

  // RGB565 with red = idx*8, green = 255 - idx*8 (both mod 256), blue = 128.
  function automatic logic [COLOR_W-1:0] bar_color_of(input logic [BAR_W-1:0] idx);
    logic [7:0] red;
    logic [7:0] green;
    red   = 8'({idx, 3'b000});
    green = ~red;
    return {red[7:3], green[7:2], BLUE_565};
  endfunction

endpackage

// ===== rtl/spbpm_level.sv =====
module spbpm_level import spbpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     acc,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output lvl_out_t lvl_out
);

  logic [2*LVL_W-1:0] mem [NUM_BARS];
  logic [NUM_BARS-1:0] ok;

  logic [BAR_W-1:0]   in_idx;
  logic               s1_valid;
  logic [BAR_W-1:0]   s1_idx;
  logic [LVL_W-1:0]   s1_mag;
  logic [2*LVL_W-1:0] rd_data;
  logic               rd_ok;

  logic               fw_valid;
  logic [BAR_W-1:0]   fw_idx;
  logic [2*LVL_W-1:0] fw_data;

  logic [LVL_W-1:0]        bl_old;
  logic [LVL_W-1:0]        pl_old;
  logic [LVL_W-1:0]        bl_new;
  logic [LVL_W-1:0]        pl_new;
  logic [COEF_W:0]         rise_w;
  logic [LVL_W-1:0]        bar_gap;
  logic [LVL_W+COEF_W:0]   fall_prod;
  logic [LVL_W-1:0]        fall_amt;
  logic [LVL_W+COEF_W-1:0] decay_prod;

  logic             o_valid;
  logic [BAR_W-1:0] o_idx;
  logic [MAG_W-1:0] o_bar_ip;
  logic [MAG_W-1:0] o_peak_ip;

  assign in_idx = in_data.bin[BAR_W-1:0];

  always_comb begin
    // The entry written at the edge that registered this read is taken from the bypass.
    if (fw_valid && fw_idx == s1_idx) begin
      {pl_old, bl_old} = fw_data;
    end else if (rd_ok) begin
      {pl_old, bl_old} = rd_data;
    end else begin
      pl_old = '0;
      bl_old = '0;
    end
    // On a fall, (s*bl + (256-s)*m) >> 8 equals bl - ceil((256-s)*(bl-m) / 256).
    rise_w    = (COEF_W+1)'(FRAC_ONE) - (COEF_W+1)'(cfg.smooth_factor);
    bar_gap   = bl_old - s1_mag;
    fall_prod = rise_w * bar_gap;
    fall_amt  = LVL_W'((fall_prod + (LVL_W+COEF_W+1)'(FRAC_ONE - 1)) >> FRAC_W);
    bl_new    = (s1_mag > bl_old) ? s1_mag : bl_old - fall_amt;
    decay_prod = pl_old * cfg.peak_fade;
    pl_new    = (s1_mag > pl_old) ? s1_mag : decay_prod[LVL_W+FRAC_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
      o_valid  <= 1'b0;
      ok       <= '0;
    end else if (adv) begin
      s1_valid <= acc;
      fw_valid <= s1_valid;
      o_valid  <= s1_valid;
      if (s1_valid) begin
        ok[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc) begin
        s1_idx  <= in_idx;
        s1_mag  <= {in_data.magnitude, {FRAC_W{1'b0}}};
        rd_data <= mem[in_idx];
        rd_ok   <= ok[in_idx];
      end
      if (s1_valid) begin
        mem[s1_idx] <= {pl_new, bl_new};
      end
      fw_idx    <= s1_idx;
      fw_data   <= {pl_new, bl_new};
      o_idx     <= s1_idx;
      o_bar_ip  <= bl_new[LVL_W-1:FRAC_W];
      o_peak_ip <= pl_new[LVL_W-1:FRAC_W];
    end
  end

  assign lvl_out = '{valid: o_valid, idx: o_idx, bar_ip: o_bar_ip, peak_ip: o_peak_ip};

endmodule

// ===== rtl/spbpm_div.sv =====
module spbpm_div import spbpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  lvl_out_t din,
  input  cfg_t     cfg,
  output div_out_t dout
);

  logic [FS_W-1:0] fs_eff;

  logic [DIV_STAGES:0] st_valid;
  logic [BAR_W-1:0]    st_idx   [DIV_STAGES+1];
  logic [PROD_W-1:0]   st_rem_b [DIV_STAGES+1];
  logic [PROD_W-1:0]   st_rem_p [DIV_STAGES+1];
  logic [PX_W-1:0]     st_q_b   [DIV_STAGES+1];
  logic [PX_W-1:0]     st_q_p   [DIV_STAGES+1];
  logic                st_sat_b [DIV_STAGES+1];
  logic                st_sat_p [DIV_STAGES+1];

  // A full scale of zero behaves as one.
  assign fs_eff = (cfg.full_scale == '0) ? FS_W'(1) : cfg.full_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (adv) begin
      st_valid <= {st_valid[DIV_STAGES-1:0], din.valid};
    end
  end

  // Stage 0: ip * height. When ip >= full scale the quotient is at least the height and
  // saturates; otherwise it is below the height and fits the quotient width.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_idx[0]   <= din.idx;
      st_rem_b[0] <= din.bar_ip * cfg.screen_height;
      st_rem_p[0] <= din.peak_ip * cfg.screen_height;
      st_q_b[0]   <= '0;
      st_q_p[0]   <= '0;
      st_sat_b[0] <= din.bar_ip >= fs_eff;
      st_sat_p[0] <= din.peak_ip >= fs_eff;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [PROD_W-1:0] rb;
    logic [PROD_W-1:0] rp;
    logic [PX_W-1:0]   qb;
    logic [PX_W-1:0]   qp;

    // Restoring division, most significant quotient bit first.
    always_comb begin
      rb = st_rem_b[j];
      rp = st_rem_p[j];
      qb = st_q_b[j];
      qp = st_q_p[j];
      for (int k = 0; k < DIV_PER_STAGE; k++) begin
        if (rb >= (PROD_W'(fs_eff) << (PX_W - 1 - j * DIV_PER_STAGE - k))) begin
          rb = rb - (PROD_W'(fs_eff) << (PX_W - 1 - j * DIV_PER_STAGE - k));
          qb = {qb[PX_W-2:0], 1'b1};
        end else begin
          qb = {qb[PX_W-2:0], 1'b0};
        end
        if (rp >= (PROD_W'(fs_eff) << (PX_W - 1 - j * DIV_PER_STAGE - k))) begin
          rp = rp - (PROD_W'(fs_eff) << (PX_W - 1 - j * DIV_PER_STAGE - k));
          qp = {qp[PX_W-2:0], 1'b1};
        end else begin
          qp = {qp[PX_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_idx[j+1]   <= st_idx[j];
        st_rem_b[j+1] <= rb;
        st_rem_p[j+1] <= rp;
        st_q_b[j+1]   <= qb;
        st_q_p[j+1]   <= qp;
        st_sat_b[j+1] <= st_sat_b[j];
        st_sat_p[j+1] <= st_sat_p[j];
      end
    end
  end

  assign dout = '{
    valid:   st_valid[DIV_STAGES],
    idx:     st_idx[DIV_STAGES],
    bar_px:  st_sat_b[DIV_STAGES] ? cfg.screen_height : st_q_b[DIV_STAGES],
    peak_px: st_sat_p[DIV_STAGES] ? cfg.screen_height : st_q_p[DIV_STAGES]
  };

endmodule

// ===== rtl/spbpm_px.sv =====
module spbpm_px import spbpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  div_out_t  din,
  output logic      res_valid,
  output out_item_t res
);

  logic [2*PX_W-1:0]   mem [NUM_BARS];
  logic [NUM_BARS-1:0] ok;

  logic               f_valid;
  logic [BAR_W-1:0]   f_idx;
  logic [PX_W-1:0]    f_bar;
  logic [PX_W-1:0]    f_peak;
  logic [2*PX_W-1:0]  rd_data;
  logic               rd_ok;

  logic               fw_valid;
  logic [BAR_W-1:0]   fw_idx;
  logic [2*PX_W-1:0]  fw_data;

  logic [PX_W-1:0] old_bar;
  logic [PX_W-1:0] old_peak;

  always_comb begin
    if (fw_valid && fw_idx == f_idx) begin
      {old_peak, old_bar} = fw_data;
    end else if (rd_ok) begin
      {old_peak, old_bar} = rd_data;
    end else begin
      old_peak = '0;
      old_bar  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid  <= 1'b0;
      fw_valid <= 1'b0;
      ok       <= '0;
    end else if (adv) begin
      f_valid  <= din.valid;
      fw_valid <= f_valid;
      if (f_valid) begin
        ok[f_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (din.valid) begin
        f_idx   <= din.idx;
        f_bar   <= din.bar_px;
        f_peak  <= din.peak_px;
        rd_data <= mem[din.idx];
        rd_ok   <= ok[din.idx];
      end
      if (f_valid) begin
        mem[f_idx] <= {f_peak, f_bar};
      end
      fw_idx  <= f_idx;
      fw_data <= {f_peak, f_bar};
    end
  end

  assign res_valid = f_valid;
  assign res = '{
    bar_bin:         BIN_W'(f_idx),
    bar_height:      f_bar,
    peak_height:     f_peak,
    old_bar_height:  old_bar,
    old_peak_height: old_peak,
    erase_bar:       f_bar < old_bar,
    erase_peak:      old_peak > f_peak,
    bar_color:       bar_color_of(f_idx)
  };

endmodule

// ===== rtl/spectrum_bar_peak_meter.sv =====
// Spectrum bar meter with peak hold. Each request carries one spectrum bin (bar index and
// unsigned magnitude) and yields exactly one result in request order: the new bar and peak
// heights in pixels, the heights reported last time for the same bar, erase flags for the
// pixel writer and an RGB565 bar color. Bin indexes wrap modulo the bar count. One request
// is accepted every clock cycle while the result side keeps up, including back-to-back
// requests for the same bar, since both per-bar memories are read as the request enters
// their stage and a one-entry bypass forwards the entry written at the previous edge. A
// result passes through the level stage, the divider, the pixel stage and the output
// register. The whole pipeline holds while a finished result waits on out_ready.
// Configuration is written through cfg_wen/cfg_index/cfg_data and must only change while
// the meter is idle.
module spectrum_bar_peak_meter import spbpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      adv;
  logic      acc;
  lvl_out_t  lvl_out;
  div_out_t  div_out;
  logic      res_valid;
  out_item_t res;

  // The pipeline moves as one unit. It advances whenever the output register is empty or
  // is being emptied this cycle, so the input side never waits on an internal state.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  // Configuration registers. Writes take effect at the edge where cfg_wen is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smooth_factor <= SMOOTH_RST;
      cfg.peak_fade     <= DECAY_RST;
      cfg.full_scale    <= FULL_RST;
      cfg.screen_height <= HEIGHT_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SMOOTH: begin
          cfg.smooth_factor <= cfg_data[COEF_W-1:0];
        end
        CFG_DECAY: begin
          cfg.peak_fade <= cfg_data[COEF_W-1:0];
        end
        CFG_FULL_SCALE: begin
          cfg.full_scale <= cfg_data[FS_W-1:0];
        end
        CFG_HEIGHT: begin
          cfg.screen_height <= cfg_data[PX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Level stage: the per-bar bar and peak levels live in a memory with a registered read. The
  // read is issued as the request is accepted, the update is computed the next cycle and
  // written back, and a one-entry bypass covers a same-bar request right behind it.
  spbpm_level u_level (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .acc     (acc),
    .in_data (in_data),
    .cfg     (cfg),
    .lvl_out (lvl_out)
  );

  // Height mapping: integer level times screen height, then a pipelined restoring divide
  // by full scale, a few quotient bits per stage, with saturation at the screen height.
  spbpm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .din  (lvl_out),
    .cfg  (cfg),
    .dout (div_out)
  );

  // Pixel stage: the last reported heights per bar sit in a second memory, read one stage
  // ahead and written back as the result leaves, with the same one-entry bypass.
  spbpm_px u_px (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .din       (div_out),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register. It holds a finished result until out_ready takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  // Heights never exceed the configured screen height.
  a_height_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.bar_height <= cfg.screen_height &&
                   out_data.peak_height <= cfg.screen_height))
    else $error("height above screen height");

  // Reset empties the pipeline and the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // A peak marker can only be erased if one was drawn before.
  a_erase_peak: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.erase_peak) |-> out_data.old_peak_height != '0)
    else $error("peak erase with no previous peak");

  // A stalled output freezes the pipeline, so no request is taken during a stall.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !acc)
    else $error("request accepted while output stalled");
`endif

endmodule
